// File: sv/rbavg_pkg.sv
// shared types and constants for the ring buffer with running average
`default_nettype none

package rbavg_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_GET   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_CNT,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// File: sv/rbavg_mem.sv
// sample store: one write port, one registered read port
`default_nettype none

module rbavg_mem
	import rbavg_pkg::*;
#(
	parameter int ENTRIES = 64,
	parameter int AW      = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [ENTRIES];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: sv/rbavg_div.sv
// radix-2 restoring divider: signed sum by unsigned count, truncating toward zero
`default_nettype none

module rbavg_div
	import rbavg_pkg::*;
#(
	parameter int SUM_W = 39
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SUM_W-1:0] dividend,
	input  wire logic        [CAP_W-1:0] divisor,
	output logic                         done,
	output logic             [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [SUM_W-1:0] acc_q;
	logic [CAP_W:0]   rem_q;
	logic [CAP_W-1:0] div_q;

	logic [CAP_W:0]   rem_sh;
	logic             ge;
	logic [CAP_W:0]   rem_nxt;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] q_signed;

	assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

	always_comb begin
		rem_sh  = {rem_q[CAP_W-1:0], acc_q[SUM_W-1]};
		ge      = (rem_sh >= {1'b0, div_q});
		rem_nxt = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= mag;
			neg_q <= dividend[SUM_W-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[SUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign q_signed = neg_q ? (~acc_q + 1'b1) : acc_q;
	assign quotient = q_signed[DATA_W-1:0];
	assign done     = done_q;

endmodule

`default_nettype wire

// File: sv/ring_buffer_with_average.sv
// ring buffer of Q16.16 samples with running sum and truncated mean
// a new item waits until the previous result is loaded; the divider makes one bit per cycle
// the sample store is read as an item is accepted; a put is written on the following cycle
// reset empties the buffer and sets capacity to 64; store contents are not cleared
// a capacity write also empties the buffer
`default_nettype none

module ring_buffer_with_average
	import rbavg_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic        [CAP_W-1:0]  cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic        [1:0]        op,
	input  wire logic signed [DATA_W-1:0] sample,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed      [DATA_W-1:0] read_data,
	output logic                          read_ok,
	output logic             [CAP_W-1:0]  occupancy,
	output logic                          is_full,
	output logic                          is_empty,
	output logic signed      [DATA_W-1:0] mean
);

	// capacity register is 7 bits, so no more than 127 entries are ever addressed
	localparam int CAP_MAX = (DEPTH < 127) ? DEPTH : 127;
	localparam int IDX_W   = $clog2(CAP_MAX);
	localparam int SUM_W   = DATA_W + IDX_W + 1;

	state_t state_q, state_nxt;

	logic [CAP_W-1:0]  capacity_q;
	logic [IDX_W-1:0]  wr_idx_q, rd_idx_q;
	logic              full_q;
	logic [SUM_W-1:0]  sum_q;
	logic [1:0]        op_q;
	logic [DATA_W-1:0] sample_q;
	logic [DATA_W-1:0] rdout_q;
	logic              ok_q;
	logic [CAP_W-1:0]  held_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic              read_ok_q;
	logic [CAP_W-1:0]  occupancy_q;
	logic              is_full_q;
	logic              is_empty_q;
	logic [DATA_W-1:0] mean_q;

	logic [CAP_W-1:0]  cap_eff;
	logic              win_bad;
	logic              in_acc;
	logic              out_load;
	logic              mem_re;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_quot;

	logic [IDX_W-1:0]  wr_nxt, rd_nxt;
	logic              full_nxt;
	logic [SUM_W-1:0]  sum_nxt;
	logic [DATA_W-1:0] rdout_nxt;
	logic              ok_nxt;
	logic [SUM_W-1:0]  old_ext, smp_ext;
	logic [IDX_W-1:0]  rd_bump, wr_bump;
	logic [CAP_W-1:0]  held;
	logic [CAP_W-1:0]  wr_ext, rd_ext;

	function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx,
		input logic [CAP_W-1:0] cap);
		logic [CAP_W:0] nxt;
		nxt = (CAP_W+1)'(idx) + 1'b1;
		return (nxt >= {1'b0, cap}) ? '0 : nxt[IDX_W-1:0];
	endfunction

	// effective capacity clamped to 1..CAP_MAX
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (capacity_q > CAP_W'(CAP_MAX)) begin
			cap_eff = CAP_W'(CAP_MAX);
		end else begin
			cap_eff = capacity_q;
		end
	end

	assign wr_ext  = CAP_W'(wr_idx_q);
	assign rd_ext  = CAP_W'(rd_idx_q);
	assign win_bad = (wr_ext >= cap_eff) || (rd_ext >= cap_eff);
	assign in_acc  = in_valid && !in_stall;

	// read the oldest entry as the item comes in
	assign mem_raddr = win_bad ? '0 : rd_idx_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_nxt = ST_UPD;
			end
			ST_UPD: state_nxt = ST_CNT;
			ST_CNT: state_nxt = ST_DIV;
			ST_DIV: begin
				if (div_done) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_stall  = 1'b1;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				mem_re   = in_valid;
			end
			ST_UPD: mem_we = (op_q == OP_PUT);
			ST_CNT: div_start = 1'b1;
			ST_OUT: out_load = !out_valid_q || !out_stall;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// read-modify-write of the buffer state
	assign old_ext = {{(SUM_W-DATA_W){mem_rdata[DATA_W-1]}}, mem_rdata};
	assign smp_ext = {{(SUM_W-DATA_W){sample_q[DATA_W-1]}}, sample_q};
	assign rd_bump = bump(rd_idx_q, cap_eff);
	assign wr_bump = bump(wr_idx_q, cap_eff);

	always_comb begin
		wr_nxt    = wr_idx_q;
		rd_nxt    = rd_idx_q;
		full_nxt  = full_q;
		sum_nxt   = sum_q;
		rdout_nxt = '0;
		ok_nxt    = 1'b0;
		case (op_q)
			OP_PUT: begin
				// full buffer drops its oldest sample
				if (full_q) begin
					rd_nxt  = rd_bump;
					sum_nxt = sum_q - old_ext + smp_ext;
				end else begin
					sum_nxt = sum_q + smp_ext;
				end
				wr_nxt   = wr_bump;
				full_nxt = (wr_bump == rd_nxt);
			end
			OP_GET: begin
				if (full_q || (wr_idx_q != rd_idx_q)) begin
					rdout_nxt = mem_rdata;
					ok_nxt    = 1'b1;
					sum_nxt   = sum_q - old_ext;
					full_nxt  = 1'b0;
					rd_nxt    = rd_bump;
				end
			end
			OP_CLEAR: begin
				wr_nxt   = '0;
				rd_nxt   = '0;
				full_nxt = 1'b0;
				sum_nxt  = '0;
			end
			default: begin
				ok_nxt = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (full_q) begin
			held = cap_eff;
		end else if (wr_ext >= rd_ext) begin
			held = wr_ext - rd_ext;
		end else begin
			held = cap_eff + wr_ext - rd_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			capacity_q <= CAP_RESET;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			full_q     <= 1'b0;
			sum_q      <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
				wr_idx_q   <= '0;
				rd_idx_q   <= '0;
				full_q     <= 1'b0;
				sum_q      <= '0;
			end else if (in_acc && win_bad) begin
				wr_idx_q <= '0;
				rd_idx_q <= '0;
				full_q   <= 1'b0;
				sum_q    <= '0;
			end else if (state_q == ST_UPD) begin
				wr_idx_q <= wr_nxt;
				rd_idx_q <= rd_nxt;
				full_q   <= full_nxt;
				sum_q    <= sum_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= op;
			sample_q <= sample;
		end
		if (state_q == ST_UPD) begin
			rdout_q <= rdout_nxt;
			ok_q    <= ok_nxt;
		end
		if (state_q == ST_CNT) begin
			held_q <= held;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			read_data_q <= rdout_q;
			read_ok_q   <= ok_q;
			occupancy_q <= held_q;
			is_full_q   <= (held_q == cap_eff);
			is_empty_q  <= (held_q == '0);
			mean_q      <= (held_q == '0) ? '0 : div_quot;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign read_ok   = read_ok_q;
	assign occupancy = occupancy_q;
	assign is_full   = is_full_q;
	assign is_empty  = is_empty_q;
	assign mean      = mean_q;

	rbavg_mem #(
		.ENTRIES(CAP_MAX),
		.AW     (IDX_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wr_idx_q),
		.wdata(sample_q),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	rbavg_div #(
		.SUM_W(SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (held),
		.done    (div_done),
		.quotient(div_quot)
	);

	// full buffer means the pointers have met
	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (wr_idx_q == rd_idx_q))
		else $error("full flag set with unequal pointers");

	// an empty buffer holds no sum
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && held_q == '0) |-> (sum_q == '0))
		else $error("nonzero running sum with empty buffer");

	// occupancy stays within the capacity window
	a_held_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (held_q <= cap_eff))
		else $error("occupancy above capacity");

	// divider finishes only while waited on
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside divide state");

	// an accepted item reaches the update state in the cycle after it is accepted
	a_upd_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_UPD))
		else $error("accepted item not processed");

endmodule

`default_nettype wire

// File: test/tb_ring_buffer_with_average.sv
// testbench for ring_buffer_with_average: directed table plus random puts, gets, clears and no-ops
`default_nettype none

module tb_ring_buffer_with_average;
	timeunit 1ns;
	timeprecision 1ps;

	import rbavg_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int ROUNDS = 12;
	localparam int ROUND_ITEMS = 127;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              read_ok;
		logic [CAP_W-1:0]  occupancy;
		logic              is_full;
		logic              is_empty;
		logic [DATA_W-1:0] mean;
	} result_t;

	typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        op;
		logic [DATA_W-1:0] value;
		logic              typed;
		result_t           want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = OP_PUT;
	logic signed [DATA_W-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] read_data;
	logic read_ok;
	logic [CAP_W-1:0] occupancy;
	logic is_full;
	logic is_empty;
	logic signed [DATA_W-1:0] mean;

	// predictor state
	logic [DATA_W-1:0] ring_store [RING_DEPTH];
	int unsigned wr_ptr = 0;
	int unsigned rd_ptr = 0;
	bit ring_full = 1'b0;
	longint ring_sum = 0;
	logic [CAP_W-1:0] cap_reg = CAP_RESET;

	result_t pending_results [$];
	result_t last_pred;
	int unsigned mismatches = 0;
	bit calm = 1'b0;
	row_t directed_rows [$];

	ring_buffer_with_average #(.DEPTH(RING_DEPTH)) uut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("ring_buffer_with_average test failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic void empty_ring();
		wr_ptr = 0;
		rd_ptr = 0;
		ring_full = 1'b0;
		ring_sum = 0;
	endfunction

	function automatic int unsigned advance(input int unsigned p, input int unsigned cap);
		return (p + 1 >= cap) ? 0 : p + 1;
	endfunction

	function automatic result_t predict_step(input logic [1:0] o, input logic [DATA_W-1:0] s);
		result_t r;
		int unsigned cap;
		int unsigned held;
		r = '0;
		if (cap_reg == 0)
			cap = 1;
		else if (cap_reg > RING_DEPTH)
			cap = RING_DEPTH;
		else
			cap = cap_reg;
		// pointers left over from a larger window are dropped
		if (wr_ptr >= cap || rd_ptr >= cap)
			empty_ring();
		case (o)
			OP_PUT: begin
				if (ring_full) begin
					ring_sum -= longint'($signed(ring_store[rd_ptr]));
					rd_ptr = advance(rd_ptr, cap);
				end
				ring_store[wr_ptr] = s;
				ring_sum += longint'($signed(s));
				wr_ptr = advance(wr_ptr, cap);
				ring_full = (wr_ptr == rd_ptr);
			end
			OP_GET: begin
				if (ring_full || wr_ptr != rd_ptr) begin
					r.read_data = ring_store[rd_ptr];
					r.read_ok = 1'b1;
					ring_sum -= longint'($signed(ring_store[rd_ptr]));
					ring_full = 1'b0;
					rd_ptr = advance(rd_ptr, cap);
				end
			end
			OP_CLEAR: empty_ring();
			default: ;
		endcase
		if (ring_full)
			held = cap;
		else if (wr_ptr >= rd_ptr)
			held = wr_ptr - rd_ptr;
		else
			held = cap + wr_ptr - rd_ptr;
		r.occupancy = held[CAP_W-1:0];
		r.is_full = (held == cap);
		r.is_empty = (held == 0);
		// longint division truncates toward zero
		if (held != 0)
			r.mean = DATA_W'(ring_sum / longint'(held));
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 32'h7FFF_FFFF;
		if (r < 20)
			return 32'h8000_0000;
		if (r < 25)
			return 32'h0000_0000;
		if (r < 30)
			return 32'hFFFF_FFFF;
		if (r < 55)
			return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
		return $urandom;
	endfunction

	function automatic row_t known_row(input logic [1:0] o, input logic [DATA_W-1:0] s,
			input logic [DATA_W-1:0] rd, input logic ok, input logic [CAP_W-1:0] occ,
			input logic full, input logic emp, input logic [DATA_W-1:0] avg);
		row_t row;
		row.kind = ROW_ITEM;
		row.op = o;
		row.value = s;
		row.typed = 1'b1;
		row.want = '{rd, ok, occ, full, emp, avg};
		return row;
	endfunction

	// item that must leave the buffer empty with a plain status result
	function automatic row_t empty_row(input logic [1:0] o, input logic [DATA_W-1:0] s);
		return known_row(o, s, '0, 1'b0, '0, 1'b0, 1'b1, '0);
	endfunction

	function automatic row_t open_row(input logic [1:0] o, input logic [DATA_W-1:0] s);
		row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.op = o;
		row.value = s;
		return row;
	endfunction

	function automatic row_t cap_row(input logic [CAP_W-1:0] c);
		row_t row;
		row = '0;
		row.kind = ROW_CAP;
		row.value = DATA_W'(c);
		return row;
	endfunction

	task automatic drive_item(input logic [1:0] o, input logic [DATA_W-1:0] s,
			input logic typed, input result_t want);
		int unsigned gap;
		result_t got;
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = predict_step(o, s);
		last_pred = got;
		pending_results.push_back(typed ? want : got);
	endtask

	// capacity is only written once the block has gone quiet
	task automatic set_capacity(input logic [CAP_W-1:0] c);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = c;
		empty_ring();
		last_pred = '0;
		last_pred.is_empty = 1'b1;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", read_data, want.read_data);
				check_field("read_ok", DATA_W'(read_ok), DATA_W'(want.read_ok));
				check_field("occupancy", DATA_W'(occupancy), DATA_W'(want.occupancy));
				check_field("is_full", DATA_W'(is_full), DATA_W'(want.is_full));
				check_field("is_empty", DATA_W'(is_empty), DATA_W'(want.is_empty));
				check_field("mean", mean, want.mean);
			end
		end
	end

	initial begin : receiver_stalls
		int unsigned n;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			n = idle_len();
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(0, 12)) @(posedge clk);
		end
	end

	initial begin : stimulus
		logic [CAP_W-1:0] c;
		logic [1:0] o;
		int unsigned r;
		bit filling;
		directed_rows = '{
			empty_row(OP_GET, 32'h1234_5678),
			empty_row(OP_CLEAR, 32'h0000_0000),
			empty_row(OP_NONE, 32'hFFFF_FFFF),
			known_row(OP_PUT, 32'h7FFF_FFFF, '0, 1'b0, 7'd1, 1'b0, 1'b0, 32'h7FFF_FFFF),
			// sum of max and min is -1, which truncates to a zero mean
			known_row(OP_PUT, 32'h8000_0000, '0, 1'b0, 7'd2, 1'b0, 1'b0, 32'h0000_0000),
			open_row(OP_PUT, 32'hFFFF_FFFD),
			open_row(OP_NONE, 32'h5555_AAAA),
			open_row(OP_GET, 32'h0000_0000),
			open_row(OP_GET, 32'hFFFF_FFFF),
			open_row(OP_GET, 32'h0000_0000),
			empty_row(OP_GET, 32'h0000_0000),
			cap_row(7'd2),
			open_row(OP_PUT, 32'h0005_0000),
			open_row(OP_PUT, 32'h0007_0000),
			open_row(OP_PUT, 32'h0009_0000),
			open_row(OP_GET, 32'h0000_0000),
			open_row(OP_PUT, 32'hFFFF_0000),
			empty_row(OP_CLEAR, 32'hFFFF_FFFF),
			cap_row(7'd0),
			open_row(OP_PUT, 32'h0001_8000),
			open_row(OP_PUT, 32'hAAAA_5555),
			open_row(OP_GET, 32'h0000_0000),
			open_row(OP_PUT, 32'h8000_0000),
			// a capacity write drops whatever is held
			cap_row(7'd127),
			empty_row(OP_GET, 32'h0000_0000),
			open_row(OP_PUT, 32'h7FFF_FFFF),
			open_row(OP_PUT, 32'h7FFF_FFFF)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CAP)
				set_capacity(directed_rows[i].value[CAP_W-1:0]);
			else
				drive_item(directed_rows[i].op, directed_rows[i].value,
						directed_rows[i].typed, directed_rows[i].want);
		end

		for (int ph = 0; ph < ROUNDS; ph++) begin
			case (ph)
				0: c = 7'd64;
				1: c = 7'd1;
				2: c = 7'd127;
				3: c = 7'd0;
				4: c = 7'd2;
				5: c = 7'd65;
				6: c = 7'd64;
				default: c = CAP_W'($urandom_range(0, 127));
			endcase
			set_capacity(c);
			calm = (ph % 4 == 3);
			filling = 1'b1;
			for (int k = 0; k < ROUND_ITEMS; k++) begin
				// swing between filling up to full and draining to empty
				if (last_pred.is_full && $urandom_range(0, 3) != 0)
					filling = 1'b0;
				if (last_pred.is_empty)
					filling = 1'b1;
				r = $urandom_range(0, 199);
				if (r < 2)
					o = OP_CLEAR;
				else if (r < 6)
					o = OP_NONE;
				else if ($urandom_range(0, 99) < (filling ? 88 : 15))
					o = OP_PUT;
				else
					o = OP_GET;
				drive_item(o, pick_sample(), 1'b0, '0);
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("ring_buffer_with_average test passed");
		else
			$display("ring_buffer_with_average test failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
sv/rbavg_pkg.sv
sv/rbavg_mem.sv
sv/rbavg_div.sv
sv/ring_buffer_with_average.sv
test/tb_ring_buffer_with_average.sv
